@@ rtl/packet_buffer_service_sim_core_defines.svh @@
// ----------------------------------------------------------------------------
// packet buffer service core: assertion macros
// shared concurrent assertion forms, clocked on clk, masked during reset
// ----------------------------------------------------------------------------
`ifndef PACKET_BUFFER_SERVICE_SIM_CORE_DEFINES_SVH
`define PACKET_BUFFER_SERVICE_SIM_CORE_DEFINES_SVH

// same-cycle implication
`define PBSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbss assertion failed");

// next-cycle implication
`define PBSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbss assertion failed");

`endif

@@ rtl/pbss_pkg.sv @@
// ----------------------------------------------------------------------------
// pbss_pkg
// types and constants shared by the packet buffer service core
// ----------------------------------------------------------------------------
`default_nettype none

package pbss_pkg;

  localparam int ARR_W  = 32;
  localparam int PROC_W = 16;
  localparam int TIME_W = 33;
  localparam int CFG_W  = 7;

  localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
  localparam logic [CFG_W-1:0]  BUF_SIZE_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_RETIRE  = 4'b0010,
    ST_DECIDE  = 4'b0100,
    ST_DELIVER = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic retire;
    logic decide;
    logic load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic retire_ok;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/pbss_ram.sv @@
// ----------------------------------------------------------------------------
// pbss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pbss_ram #(
  parameter int WIDTH  = 33,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/pbss_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbss_ctrl
// sequencer: accept, retire finished entries, decide, deliver result
// ----------------------------------------------------------------------------
`default_nettype none

module pbss_ctrl
  import pbss_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RETIRE;
        end
      end
      ST_RETIRE: begin
        if (sts.retire_ok) begin
          cmd.retire = 1'b1;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/pbss_dp.sv @@
// ----------------------------------------------------------------------------
// pbss_dp
// queue pointers, occupancy, start and finish arithmetic, result registers
// ----------------------------------------------------------------------------
`default_nettype none

module pbss_dp
  import pbss_pkg::*;
#(
  parameter int DEPTH  = 64,
  parameter int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  input  wire logic [ARR_W-1:0]  in_arrival_time,
  input  wire logic [PROC_W-1:0] in_process_time,
  output logic                   out_dropped,
  output logic [TIME_W-1:0]      out_start_time,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_buffer_size,
  // store ports
  output logic                   mem_wr_en,
  output logic [IDX_W-1:0]       mem_wr_addr,
  output logic [TIME_W-1:0]      mem_wr_data,
  output logic [IDX_W-1:0]       mem_rd_addr,
  input  wire logic [TIME_W-1:0] mem_rd_data
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CNT_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  logic [CFG_W-1:0]  buf_size_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [TIME_W-1:0] last_r;
  logic [ARR_W-1:0]  arr_r;
  logic [PROC_W-1:0] proc_r;
  logic              res_dropped_r;
  logic [TIME_W-1:0] res_start_r;
  logic              out_dropped_r;
  logic [TIME_W-1:0] out_start_r;

  logic [CNT_W-1:0]  cap;
  logic              drop;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] start;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] finish;
  logic              push;

  assign arr_ext = {1'b0, arr_r};

  // capacity saturates at the store depth
  assign cap = (CNT_W'(buf_size_r) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(buf_size_r);
  assign drop = (CNT_W'(occ_r) >= cap);

  assign start  = ((occ_r != '0) && (last_r > arr_ext)) ? last_r : arr_ext;
  assign sum    = {1'b0, start} + (TIME_W + 1)'(proc_r);
  assign finish = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign push   = cmd.decide && !drop;

  assign sts.retire_ok = (occ_r != '0) && (mem_rd_data <= arr_ext);

  always_comb begin
    head_nxt = head_r;
    if (cmd.retire) begin
      head_nxt = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_comb begin
    tail_nxt = tail_r;
    if (push) begin
      tail_nxt = (tail_r == IDX_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.retire) begin
      occ_nxt = occ_r - 1'b1;
    end else if (push) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= BUF_SIZE_RESET;
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
    end else begin
      if (cfg_valid) begin
        buf_size_r <= cfg_buffer_size;
      end
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      arr_r  <= in_arrival_time;
      proc_r <= in_process_time;
    end
    if (push) begin
      last_r <= finish;
    end
    if (cmd.decide) begin
      res_dropped_r <= drop;
      res_start_r   <= drop ? '0 : start;
    end
    if (cmd.load) begin
      out_dropped_r <= res_dropped_r;
      out_start_r   <= res_start_r;
    end
  end

  // head entry is re-read every cycle
  assign mem_rd_addr = head_nxt;
  assign mem_wr_en   = push;
  assign mem_wr_addr = tail_r;
  assign mem_wr_data = finish;

  assign cfg_ready      = 1'b1;
  assign out_dropped    = out_dropped_r;
  assign out_start_time = out_start_r;

endmodule

`default_nettype wire

@@ rtl/packet_buffer_service_sim_core.sv @@
// result path: an accepted request runs the retire loop, then decide, then deliver into the
// output register, which waits while a stalled result is held there; no new request is taken until then;
// the retire loop walks one entry a cycle through the single read port of the finish store
// reset: rst_n synchronous, active low; empty queue, buffer size 64, no clearing pass
// ----------------------------------------------------------------------------
// packet_buffer_service_sim_core
// single server with a finite buffer and tail drop; one result per request
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_buffer_service_sim_core_defines.svh"

module packet_buffer_service_sim_core
  import pbss_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [ARR_W-1:0]  in_arrival_time,
  input  wire logic [PROC_W-1:0] in_process_time,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_dropped,
  output logic [TIME_W-1:0]      out_start_time,
  // buffer size register
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_buffer_size
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [TIME_W-1:0] mem_wr_data;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [TIME_W-1:0] mem_rd_data;

  // sequencer: idle, retire loop, decide, deliver into the output register
  pbss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // pointers, occupancy and the start time arithmetic
  pbss_dp #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_arrival_time (in_arrival_time),
    .in_process_time (in_process_time),
    .out_dropped     (out_dropped),
    .out_start_time  (out_start_time),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_buffer_size (cfg_buffer_size),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_data     (mem_wr_data),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_data     (mem_rd_data)
  );

  // circular store of finish times; read data is used only while the queue is occupied
  pbss_ram #(
    .WIDTH  (TIME_W),
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W)
  ) u_finish_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // one request in flight: an accepted request blocks the next one
  `PBSS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a dropped request reports a zero start time
  `PBSS_ASSERT_SAME(a_drop_zero_start, out_valid && out_dropped, out_start_time == '0)
  // the sequencer issues at most one command per cycle
  `PBSS_ASSERT_SAME(a_cmd_onehot, 1'b1,
                    $onehot0({cmd.accept, cmd.retire, cmd.decide, cmd.load}))
  // no store write while the retire loop is walking the queue
  `PBSS_ASSERT_SAME(a_no_write_in_retire, cmd.retire, !mem_wr_en)

endmodule

`default_nettype wire
